### design/pirl_pkg.sv
// Shared types and codes for the positional insert/remove list.
package pirl_pkg;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdRemove = 2'd1,
    CmdPush   = 2'd2,
    CmdPop    = 2'd3
  } pirl_cmd_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusFull    = 2'd1,
    StatusBadPos  = 2'd2,
    StatusInvalid = 2'd3
  } pirl_status_e;

  typedef struct packed {
    pirl_cmd_e   cmd;
    logic [7:0]  position;
    logic [7:0]  data;
  } pirl_in_t;

  typedef struct packed {
    pirl_status_e status;
    logic [7:0]   count;
    logic [7:0]   top_entry;
  } pirl_out_t;

  // Broadcast to every cell: shift direction and the byte to be written.
  typedef struct packed {
    logic       up;
    logic       down;
    logic [7:0] data;
  } pirl_op_t;

endpackage

### design/pirl_cell.sv
// One storage cell of the list: holds a byte and moves it to or from its neighbours.
module pirl_cell #(
  parameter int IDXW  = 7,
  parameter int INDEX = 0
) (
  input  logic               clk_i,
  input  pirl_pkg::pirl_op_t op_i,
  input  logic [IDXW-1:0]    sel_i,
  input  logic [7:0]         left_i,
  input  logic [7:0]         right_i,
  output logic [7:0]         value_o,
  output logic [7:0]         next_o
);

  localparam logic [IDXW-1:0] MyIdx = IDXW'(INDEX);

  logic [7:0] value_q;
  logic [7:0] value_d;

  // Cells are numbered from the end of the list, so cell 0 always holds the last entry.
  always_comb begin
    value_d = value_q;
    if (op_i.up) begin
      if (MyIdx > sel_i) begin
        value_d = left_i;
      end else if (MyIdx == sel_i) begin
        value_d = op_i.data;
      end
    end else if (op_i.down) begin
      if (MyIdx >= sel_i) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign next_o  = value_d;

endmodule

### design/pirl_ctrl.sv
// Command decode and fill count for the list: checks each command and drives the cell row.
module pirl_ctrl #(
  parameter int DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  pirl_pkg::pirl_in_t         word_i,
  output pirl_pkg::pirl_op_t         op_o,
  output logic [$clog2(DEPTH)-1:0]   sel_o,
  output pirl_pkg::pirl_status_e     status_o,
  output logic [$clog2(DEPTH+1)-1:0] count_d_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);
  localparam int CMPW = (CNTW > 8) ? CNTW : 8;

  logic [CNTW-1:0] count_q;
  logic [CNTW-1:0] count_d;
  logic [CMPW-1:0] cnt_w;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] ins_sel;
  logic [CMPW-1:0] rem_sel;
  logic            full;
  logic            empty;
  logic            up;
  logic            down;

  assign cnt_w   = CMPW'(count_q);
  assign pos_w   = CMPW'(word_i.position);
  assign ins_sel = cnt_w - pos_w;
  assign rem_sel = cnt_w - pos_w - CMPW'(1);
  assign full    = (count_q == CNTW'(DEPTH));
  assign empty   = (count_q == '0);

  always_comb begin
    up       = 1'b0;
    down     = 1'b0;
    sel_o    = '0;
    status_o = pirl_pkg::StatusOk;
    unique case (word_i.cmd)
      pirl_pkg::CmdInsert: begin
        if (full) begin
          status_o = pirl_pkg::StatusFull;
        end else if (pos_w > cnt_w) begin
          status_o = pirl_pkg::StatusBadPos;
        end else begin
          up    = 1'b1;
          sel_o = ins_sel[IDXW-1:0];
        end
      end
      pirl_pkg::CmdRemove: begin
        if (pos_w >= cnt_w) begin
          status_o = pirl_pkg::StatusInvalid;
        end else begin
          down  = 1'b1;
          sel_o = rem_sel[IDXW-1:0];
        end
      end
      pirl_pkg::CmdPush: begin
        if (full) begin
          status_o = pirl_pkg::StatusFull;
        end else begin
          up = 1'b1;
        end
      end
      default: begin
        if (empty) begin
          status_o = pirl_pkg::StatusInvalid;
        end else begin
          down = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    op_o.up   = accept_i & up;
    op_o.down = accept_i & down;
    op_o.data = word_i.data;
  end

  always_comb begin
    count_d = count_q;
    if (up) begin
      count_d = count_q + CNTW'(1);
    end else if (down) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign count_d_o = count_d;
  assign count_o   = count_q;

endmodule

### design/positional_insert_remove_list_top.sv
// Top level of the positional insert/remove list: control, cell row and result register.
//
// Usage: one command word enters on the input channel (in_valid_i, in_word_i,
// in_stall_o) and exactly one result word leaves on the output channel
// (out_valid_o, out_word_o, out_stall_i). A word moves at a rising edge where
// valid is high and stall is low.
// All cells shift together towards or away from the insertion point, so the
// result word appears in the cycle after the command is taken, and a new
// command can be taken in every cycle while the receiver does not stall.
// The store is a row of DEPTH byte cells kept in reverse order, so cell 0
// always holds the last entry and the top entry needs no wide read mux.
// The single result register sets the rate: a command is taken only while the
// register is empty or its word is being taken in the same cycle. When the
// receiver stalls, the result word holds and the input is stalled in turn.
// Reset clears the fill count and the result valid flag; the cell contents are
// not reset, since no entry is ever read before it has been written.
// The count field carries the low eight bits of the fill count.
module positional_insert_remove_list_top #(
  parameter int DEPTH = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pirl_pkg::pirl_in_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pirl_pkg::pirl_out_t  out_word_o
);

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);
  localparam int OUTW = (CNTW > 8) ? CNTW : 8;

  logic                   accept;
  pirl_pkg::pirl_op_t     op;
  logic [IDXW-1:0]        sel;
  pirl_pkg::pirl_status_e status;
  logic [CNTW-1:0]        count_d;
  logic [CNTW-1:0]        count_q;
  logic [7:0]             vals [DEPTH];
  logic [7:0]             top_next;
  logic [OUTW-1:0]        count_wide;

  logic                   out_valid_q;
  pirl_pkg::pirl_out_t    out_word_q;
  pirl_pkg::pirl_out_t    out_word_d;

  // The result register may be refilled in the same cycle its word leaves.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  pirl_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .op_o     (op),
    .sel_o    (sel),
    .status_o (status),
    .count_d_o(count_d),
    .count_o  (count_q)
  );

  // Cell k holds list index count-1-k. The left neighbour of cell k is cell k-1;
  // cell 0 has none and the end cell has no right neighbour.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      pirl_cell #(
        .IDXW (IDXW),
        .INDEX(k)
      ) u_cell (
        .clk_i  (clk_i),
        .op_i   (op),
        .sel_i  (sel),
        .left_i (op.data),
        .right_i(vals[k+1]),
        .value_o(vals[k]),
        .next_o (top_next)
      );
    end else if (k == DEPTH - 1) begin : g_last
      pirl_cell #(
        .IDXW (IDXW),
        .INDEX(k)
      ) u_cell (
        .clk_i  (clk_i),
        .op_i   (op),
        .sel_i  (sel),
        .left_i (vals[k-1]),
        .right_i(vals[k]),
        .value_o(vals[k]),
        .next_o ()
      );
    end else begin : g_mid
      pirl_cell #(
        .IDXW (IDXW),
        .INDEX(k)
      ) u_cell (
        .clk_i  (clk_i),
        .op_i   (op),
        .sel_i  (sel),
        .left_i (vals[k-1]),
        .right_i(vals[k+1]),
        .value_o(vals[k]),
        .next_o ()
      );
    end
  end

  assign count_wide = OUTW'(count_d);

  always_comb begin
    out_word_d.status    = status;
    out_word_d.count     = count_wide[7:0];
    out_word_d.top_entry = (count_d == '0) ? 8'd0 : top_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The fill count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(DEPTH))
    else $error("fill count beyond depth");

  // Every accepted command leaves a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted command gave no result");

  // A growing shift raises the count by exactly one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.up |=> (count_q == $past(count_q) + CNTW'(1)))
    else $error("insert did not raise count by one");

  // A result reporting success for a push carries the pushed byte on top.
  a_push_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_word_i.cmd == pirl_pkg::CmdPush && status == pirl_pkg::StatusOk)
      |=> (out_word_q.top_entry == $past(in_word_i.data)))
    else $error("push result does not show pushed byte");

endmodule
